@@ design/seq_numbered_pending_ring_top_defines.svh @@
// ----------------------------------------------------------------------------
// seq_numbered_pending_ring_top_defines.svh
// Assertion macros used by the command tracking ring top.
// ----------------------------------------------------------------------------
`ifndef SEQ_NUMBERED_PENDING_RING_TOP_DEFINES_SVH
`define SEQ_NUMBERED_PENDING_RING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SNPR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("snpr: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define SNPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("snpr: next-cycle check failed");
`else
`define SNPR_ASSERT_NOW(label, clk, rstn, ante, cons)
`define SNPR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ design/snpr_pkg.sv @@
// ----------------------------------------------------------------------------
// snpr_pkg
// Types and codes shared by the command tracking ring modules.
// ----------------------------------------------------------------------------
`default_nettype none

package snpr_pkg;

    localparam int SEQ_W  = 64;
    localparam int TAG_W  = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_SUBMIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OLDEST   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RETRY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FUTURE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_in;
        logic [TAG_W-1:0]  job_tag;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEQ_W-1:0]  seq_out;
        logic [TAG_W-1:0]  tag_out;
        logic              in_flight;
        logic              released_valid;
        logic [TAG_W-1:0]  released_tag;
    } rsp_t;

    typedef struct packed {
        logic load;     // capture the request beat
        logic diff;     // form next_seq - seq_in
        logic resolve;  // pick the slot, read tag and flags
        logic commit;   // load result register, update ring state
    } ctl_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_RESOLVE,
        ST_FINISH
    } ctl_state_t;

endpackage

`default_nettype wire

@@ design/seq_numbered_pending_ring_top.sv @@
// ----------------------------------------------------------------------------
// seq_numbered_pending_ring_top
// Command tracking ring addressed by a rising 64-bit sequence number.
// ----------------------------------------------------------------------------
// Use:
//   Requests arrive as beats on s_valid/s_ready/s_data: submit a job tag,
//   complete a job by sequence, look up a job by sequence, or look up the
//   oldest slot. Every request beat yields exactly one result beat on
//   m_valid/m_ready/m_data (status, assigned sequence, found tag, in-flight
//   flag, and the tag of a finished job released by a submit).
// Steps:
//   One request is handled at a time: a new request is taken only once the
//   last one has built its result. The four steps are the controller's walk:
//   capture, 65-bit distance subtract, slot select with tag store read,
//   result build and ring update.
// Stall:
//   The result sits in an output register. While the receiver stalls, the
//   next request is still taken and carried up to its update step, where it
//   holds until the pending result beat is taken.
// Reset:
//   aresetn clears the sequence counter and all slot flags at once; the tag
//   store needs no clearing, a tag is read only from a slot marked used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seq_numbered_pending_ring_top_defines.svh"

module seq_numbered_pending_ring_top #(
    parameter int SLOTS    = 16,
    parameter int TAG_BITS = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire snpr_pkg::req_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output snpr_pkg::rsp_t       m_data
);

    // Command bundle from the sequencer to the datapath.
    snpr_pkg::ctl_cmd_t cmd;

    // Sequencer: handshakes on both channels, one step per cycle except while the update step waits on the output.
    snpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: counter, slot flags, tag store and the result register.
    snpr_dpath #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

    // Drop ready right after a beat is taken: one request in flight.
    `SNPR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // Never overwrite a result beat the receiver has not taken.
    `SNPR_ASSERT_NOW(a_commit_free, aclk, aresetn, cmd.commit, !m_valid || m_ready)
    // A refused submit assigns no sequence and releases nothing.
    `SNPR_ASSERT_NOW(a_retry_clean, aclk, aresetn,
        m_valid && (m_data.status == snpr_pkg::ST_RETRY),
        (m_data.seq_out == '0) && !m_data.released_valid)
    // A release only comes with a successful submit.
    `SNPR_ASSERT_NOW(a_release_ok, aclk, aresetn,
        m_valid && m_data.released_valid,
        (m_data.status == snpr_pkg::ST_OK) && (m_data.tag_out == '0))

endmodule

`default_nettype wire

@@ design/snpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// snpr_ctrl
// Sequencer for the tracking ring: steps one request through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module snpr_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output snpr_pkg::ctl_cmd_t       cmd
);

    snpr_pkg::ctl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic commit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= snpr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Commit only once the result register is free or drains this cycle.
    assign commit = (state_reg == snpr_pkg::ST_FINISH) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            snpr_pkg::ST_IDLE: begin
                if (s_valid) state_next = snpr_pkg::ST_DIFF;
            end
            snpr_pkg::ST_DIFF:    state_next = snpr_pkg::ST_RESOLVE;
            snpr_pkg::ST_RESOLVE: state_next = snpr_pkg::ST_FINISH;
            snpr_pkg::ST_FINISH: begin
                if (commit) state_next = snpr_pkg::ST_IDLE;
            end
            default: state_next = snpr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == snpr_pkg::ST_IDLE);
        cmd.load       = s_ready && s_valid;
        cmd.diff       = (state_reg == snpr_pkg::ST_DIFF);
        cmd.resolve    = (state_reg == snpr_pkg::ST_RESOLVE);
        cmd.commit     = commit;
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ design/snpr_dpath.sv @@
// ----------------------------------------------------------------------------
// snpr_dpath
// Ring datapath: sequence counter, slot flags, tag store, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module snpr_dpath #(
    parameter int SLOTS    = 16,
    parameter int TAG_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire snpr_pkg::ctl_cmd_t  cmd,
    input  wire snpr_pkg::req_t      s_data,
    output snpr_pkg::rsp_t           m_data
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int DIST_W  = $clog2(SLOTS + 1);
    localparam int SUM_W   = DIST_W + 1;
    localparam int STORE_W = (TAG_BITS < snpr_pkg::TAG_W) ? TAG_BITS : snpr_pkg::TAG_W;
    localparam int SEQ_W   = snpr_pkg::SEQ_W;

    snpr_pkg::req_t          req_reg;
    logic [SEQ_W:0]          diff_reg, diff_next;
    logic [SEQ_W-1:0]        next_seq_reg;
    logic [IDX_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic                    future_reg, far_reg;
    logic [IDX_W-1:0]        idx_reg, sel_idx, back_idx;
    logic                    used_hit_reg, busy_hit_reg;
    logic [STORE_W-1:0]      tag_rd_reg;
    logic [SLOTS-1:0]        used_reg, busy_reg;
    logic [STORE_W-1:0]      tag_mem [SLOTS];
    snpr_pkg::rsp_t          rsp_reg, rsp_next;

    logic [SUM_W-1:0]        ptr_ext, dist_ext, back_ext;
    logic                    future_now, far_now;
    logic                    submit_ok, complete_ok;
    localparam int STAT_W_L = snpr_pkg::STAT_W;
    logic [STAT_W_L-1:0]     seq_status;

    assign diff_next = {1'b0, next_seq_reg} - {1'b0, req_reg.seq_in};

    // Slot of a resolved sequence: step back from the write pointer by the distance.
    always_comb begin
        future_now = diff_reg[SEQ_W] || (diff_reg[SEQ_W-1:0] == '0);
        far_now    = (diff_reg[SEQ_W-1:0] > SEQ_W'(SLOTS));
        ptr_ext    = SUM_W'(wr_ptr_reg);
        dist_ext   = SUM_W'(diff_reg[DIST_W-1:0]);
        if (ptr_ext >= dist_ext) begin
            back_ext = ptr_ext - dist_ext;
        end else begin
            back_ext = ptr_ext + SUM_W'(SLOTS) - dist_ext;
        end
        back_idx = back_ext[IDX_W-1:0];
        if (req_reg.kind inside {snpr_pkg::KIND_SUBMIT, snpr_pkg::KIND_OLDEST}) begin
            sel_idx = wr_ptr_reg;
        end else begin
            sel_idx = back_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= s_data;
        if (cmd.diff) diff_reg <= diff_next;
        if (cmd.resolve) begin
            future_reg   <= future_now;
            far_reg      <= far_now;
            idx_reg      <= sel_idx;
            used_hit_reg <= used_reg[sel_idx];
            busy_hit_reg <= busy_reg[sel_idx];
        end
        if (cmd.commit) rsp_reg <= rsp_next;
    end

    // Tag store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.resolve) tag_rd_reg <= tag_mem[sel_idx];
    end

    always_ff @(posedge aclk) begin
        if (submit_ok) tag_mem[wr_ptr_reg] <= req_reg.job_tag[STORE_W-1:0];
    end

    // Result of the request held in req_reg.
    always_comb begin
        rsp_next    = '0;
        submit_ok   = 1'b0;
        complete_ok = 1'b0;
        seq_status  = future_reg ? snpr_pkg::ST_FUTURE :
                      (far_reg || !used_hit_reg) ? snpr_pkg::ST_NOTFOUND : snpr_pkg::ST_OK;
        case (req_reg.kind)
            snpr_pkg::KIND_SUBMIT: begin
                if (used_hit_reg && busy_hit_reg) begin
                    rsp_next.status = snpr_pkg::ST_RETRY;
                end else begin
                    rsp_next.status         = snpr_pkg::ST_OK;
                    rsp_next.seq_out        = next_seq_reg;
                    rsp_next.released_valid = used_hit_reg;
                    if (used_hit_reg) rsp_next.released_tag = snpr_pkg::TAG_W'(tag_rd_reg);
                    submit_ok = cmd.commit;
                end
            end
            snpr_pkg::KIND_COMPLETE, snpr_pkg::KIND_LOOKUP: begin
                rsp_next.status = seq_status;
                if (seq_status == snpr_pkg::ST_OK) begin
                    rsp_next.tag_out   = snpr_pkg::TAG_W'(tag_rd_reg);
                    rsp_next.in_flight = busy_hit_reg;
                    complete_ok = cmd.commit && (req_reg.kind == snpr_pkg::KIND_COMPLETE);
                end
            end
            snpr_pkg::KIND_OLDEST: begin
                if (used_hit_reg) begin
                    rsp_next.status    = snpr_pkg::ST_OK;
                    rsp_next.tag_out   = snpr_pkg::TAG_W'(tag_rd_reg);
                    rsp_next.in_flight = busy_hit_reg;
                end else begin
                    rsp_next.status = snpr_pkg::ST_NOTFOUND;
                end
            end
            default: rsp_next = '0;
        endcase
    end

    assign wr_ptr_next = (wr_ptr_reg == IDX_W'(SLOTS - 1)) ? '0 : wr_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_seq_reg <= '0;
            wr_ptr_reg   <= '0;
            used_reg     <= '0;
            busy_reg     <= '0;
        end else begin
            if (submit_ok) begin
                next_seq_reg         <= next_seq_reg + 1'b1;
                wr_ptr_reg           <= wr_ptr_next;
                used_reg[wr_ptr_reg] <= 1'b1;
                busy_reg[wr_ptr_reg] <= 1'b1;
            end
            if (complete_ok) busy_reg[idx_reg] <= 1'b0;
        end
    end

    assign m_data = rsp_reg;

endmodule

`default_nettype wire
